// ===== sv/bae_pkg.sv =====
// Shared types, constants, the checksum step and the charset lookup for the bech32 address encoder.
`default_nettype none
package bae_pkg;

    localparam int unsigned PREFIX_BYTES = 8;
    localparam logic [3:0] MAX_PREFIX_LENGTH = 4'd8;
    localparam logic [6:0] SEP_CHAR = 7'h31;
    localparam logic [29:0] CKS_INIT = 30'd1;

    localparam logic REG_PREFIX_CHARS = 1'b0;
    localparam logic REG_PREFIX_LENGTH = 1'b1;

    localparam logic [255:0] CHARSET = "qpzry9x8gf2tvdw0s3jn54khce6mua7l";
    localparam logic [4:0][29:0] GEN = {
        30'h2a1462b3, 30'h3d4233dd, 30'h1ea119fa, 30'h26508e6d, 30'h3b6a57b2
    };

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_HIGH,
        ST_SEP,
        ST_LOW,
        ST_DATA0,
        ST_DATA1,
        ST_PAD,
        ST_ZERO,
        ST_CHECK
    } state_t;

    typedef enum logic [2:0] {
        CK_HOLD,
        CK_FOLD,
        CK_CLOSE,
        CK_SHIFT,
        CK_INIT
    } cks_op_t;

    typedef struct packed {
        cks_op_t    op;
        logic [4:0] sym;
    } cks_ctrl_t;

    typedef struct packed {
        logic [6:0] ch;
        logic       fin;
    } out_word_t;

    // one BCH polymod step
    function automatic logic [29:0] fold(input logic [29:0] acc, input logic [4:0] sym);
        logic [4:0]  top;
        logic [29:0] res;
        top = acc[29:25];
        res = {acc[24:0], sym};
        for (int j = 0; j < 5; j++) begin
            if (top[j]) begin
                res = res ^ GEN[j];
            end
        end
        return res;
    endfunction

    function automatic logic [6:0] charset_char(input logic [4:0] sym);
        logic [7:0] c;
        c = CHARSET[{5'd31 - sym, 3'b000} +: 8];
        return c[6:0];
    endfunction

endpackage
`default_nettype wire

// ===== sv/bae_checksum.sv =====
// Polymod accumulator: fold, close, shift-out and reinit.
`default_nettype none
module bae_checksum (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire bae_pkg::cks_ctrl_t ctrl,
    output logic [4:0]              acc_top
);

    logic [29:0] acc_reg;
    logic [29:0] acc_next;
    logic [29:0] closed;

    always_comb begin
        closed = acc_reg;
        for (int i = 0; i < 6; i++) begin
            closed = bae_pkg::fold(closed, 5'd0);
        end
        closed = closed ^ 30'd1;
    end

    always_comb begin
        unique case (ctrl.op)
            bae_pkg::CK_HOLD:  acc_next = acc_reg;
            bae_pkg::CK_FOLD:  acc_next = bae_pkg::fold(acc_reg, ctrl.sym);
            bae_pkg::CK_CLOSE: acc_next = closed;
            bae_pkg::CK_SHIFT: acc_next = {acc_reg[24:0], 5'd0};
            bae_pkg::CK_INIT:  acc_next = bae_pkg::CKS_INIT;
            default:           acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= bae_pkg::CKS_INIT;
        end else begin
            acc_reg <= acc_next;
        end
    end

    assign acc_top = acc_reg[29:25];

endmodule
`default_nettype wire

// ===== sv/bae_out_slot.sv =====
// Output register for the character stream.
`default_nettype none
module bae_out_slot (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               load,
    input  wire bae_pkg::out_word_t word_in,
    output logic                    slot_free,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [6:0]              m_address_char,
    output logic                    m_final_char
);

    logic              valid_reg;
    bae_pkg::out_word_t word_reg;

    assign slot_free = !valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            word_reg <= word_in;
        end
    end

    assign m_valid        = valid_reg;
    assign m_address_char = word_reg.ch;
    assign m_final_char   = word_reg.fin;

endmodule
`default_nettype wire

// ===== sv/bech32_address_encoder.sv =====
// Top level: bech32 address encoder, byte words in, address characters out.
//
//  channel  | ports                                 | direction
//  s_       | s_valid s_ready s_data_byte s_last_byte | byte words in
//  m_       | m_valid m_ready m_address_char m_final_char | characters out
//  apb      | psel penable pwrite paddr pwdata prdata pready | config, 64-bit
//
// A middle byte yields one or two characters (one per 5-bit symbol).
// A first byte first adds the prefix steps: prefix out with high fold, '1', low fold.
// A last byte adds an optional pad symbol, a closing step and six checksum characters.
// Next word is taken in the cycle the current word's last character is loaded.
// Output stall (m_ready low with a word held) freezes the sequencer in its emitting states.
// Reset is synchronous, active low; prefix registers return to their default, length 3.
`default_nettype none
module bech32_address_encoder (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_data_byte,
    input  wire logic        s_last_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [6:0]       m_address_char,
    output logic             m_final_char,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic [63:0]      prdata,
    output logic             pready
);

    bae_pkg::state_t state_reg, state_next;
    logic [2:0]  pidx_reg, pidx_next;
    logic [2:0]  cidx_reg, cidx_next;
    logic [11:0] buf_reg, buf_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic        in_message_reg, in_message_next;
    logic [7:0]  byte_reg;
    logic        last_reg;
    logic [63:0] prefix_chars_reg;
    logic [3:0]  prefix_length_reg;

    logic        reg_idx;
    logic        cfg_wr;
    logic [3:0]  len;
    logic        pidx_last;
    logic [6:0]  pchar;
    logic [11:0] wbuf;
    logic [3:0]  wcnt;
    logic [2:0]  cnt_after0;
    logic [4:0]  sym0;
    logic [4:0]  sym1;
    logic [4:0]  psym;
    logic [4:0]  acc_top;
    logic        emits;
    logic        slot_free;
    logic        adv;
    logic        done;
    logic        emit;
    logic        accept;
    logic        start_inm;
    bae_pkg::cks_ctrl_t ck;
    bae_pkg::cks_ctrl_t ck_eff;
    bae_pkg::out_word_t ow;

    // config port
    assign reg_idx = 1'(paddr >> 3);
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign pready  = 1'b1;
    assign prdata  = (reg_idx == bae_pkg::REG_PREFIX_CHARS) ? prefix_chars_reg
                                                             : {60'd0, prefix_length_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prefix_chars_reg  <= 64'd6450019;
            prefix_length_reg <= 4'd3;
        end else if (cfg_wr) begin
            if (reg_idx == bae_pkg::REG_PREFIX_CHARS) begin
                prefix_chars_reg <= pwdata;
            end else begin
                prefix_length_reg <= pwdata[3:0];
            end
        end
    end

    // datapath terms
    assign len = (prefix_length_reg > bae_pkg::MAX_PREFIX_LENGTH) ? bae_pkg::MAX_PREFIX_LENGTH
                                                                 : prefix_length_reg;
    assign pidx_last  = ({1'b0, pidx_reg} == (len - 4'd1));
    assign pchar      = prefix_chars_reg[{pidx_reg, 3'b000} +: 7];
    assign wbuf       = {buf_reg[3:0], byte_reg};
    assign wcnt       = {1'b0, cnt_reg} + 4'd8;
    assign cnt_after0 = 3'(wcnt - 4'd5);
    assign sym0       = 5'(wbuf >> (wcnt - 4'd5));
    assign sym1       = 5'(buf_reg >> (cnt_reg - 3'd5));
    assign psym       = 5'(buf_reg << (3'd5 - cnt_reg));

    always_comb begin
        unique case (state_reg)
            bae_pkg::ST_HIGH, bae_pkg::ST_SEP, bae_pkg::ST_DATA0,
            bae_pkg::ST_DATA1, bae_pkg::ST_PAD, bae_pkg::ST_CHECK: emits = 1'b1;
            default: emits = 1'b0;
        endcase
    end

    assign adv = !emits || slot_free;

    always_comb begin
        state_next      = state_reg;
        pidx_next       = pidx_reg;
        cidx_next       = cidx_reg;
        buf_next        = buf_reg;
        cnt_next        = cnt_reg;
        in_message_next = in_message_reg;
        ck              = '{op: bae_pkg::CK_HOLD, sym: 5'd0};
        ow              = '{ch: 7'd0, fin: 1'b0};
        emit            = 1'b0;
        done            = 1'b0;

        unique case (state_reg)
            bae_pkg::ST_IDLE: begin
            end
            bae_pkg::ST_HIGH: begin
                ck   = '{op: bae_pkg::CK_FOLD, sym: {3'd0, pchar[6:5]}};
                ow   = '{ch: pchar, fin: 1'b0};
                emit = 1'b1;
                if (pidx_last) begin
                    state_next = bae_pkg::ST_SEP;
                end else begin
                    pidx_next = pidx_reg + 3'd1;
                end
            end
            bae_pkg::ST_SEP: begin
                ck   = '{op: bae_pkg::CK_FOLD, sym: 5'd0};
                ow   = '{ch: bae_pkg::SEP_CHAR, fin: 1'b0};
                emit = 1'b1;
                pidx_next = 3'd0;
                state_next = (len == 4'd0) ? bae_pkg::ST_DATA0 : bae_pkg::ST_LOW;
            end
            bae_pkg::ST_LOW: begin
                ck = '{op: bae_pkg::CK_FOLD, sym: pchar[4:0]};
                if (pidx_last) begin
                    state_next = bae_pkg::ST_DATA0;
                end else begin
                    pidx_next = pidx_reg + 3'd1;
                end
            end
            bae_pkg::ST_DATA0: begin
                ck       = '{op: bae_pkg::CK_FOLD, sym: sym0};
                ow       = '{ch: bae_pkg::charset_char(sym0), fin: 1'b0};
                emit     = 1'b1;
                buf_next = wbuf;
                cnt_next = cnt_after0;
                if (cnt_after0 >= 3'd5) begin
                    state_next = bae_pkg::ST_DATA1;
                end else if (last_reg) begin
                    state_next = (cnt_after0 != 3'd0) ? bae_pkg::ST_PAD : bae_pkg::ST_ZERO;
                end else begin
                    done = 1'b1;
                end
            end
            bae_pkg::ST_DATA1: begin
                ck       = '{op: bae_pkg::CK_FOLD, sym: sym1};
                ow       = '{ch: bae_pkg::charset_char(sym1), fin: 1'b0};
                emit     = 1'b1;
                cnt_next = cnt_reg - 3'd5;
                if (last_reg) begin
                    state_next = (cnt_reg != 3'd5) ? bae_pkg::ST_PAD : bae_pkg::ST_ZERO;
                end else begin
                    done = 1'b1;
                end
            end
            bae_pkg::ST_PAD: begin
                ck   = '{op: bae_pkg::CK_FOLD, sym: psym};
                ow   = '{ch: bae_pkg::charset_char(psym), fin: 1'b0};
                emit = 1'b1;
                state_next = bae_pkg::ST_ZERO;
            end
            bae_pkg::ST_ZERO: begin
                ck         = '{op: bae_pkg::CK_CLOSE, sym: 5'd0};
                cidx_next  = 3'd0;
                state_next = bae_pkg::ST_CHECK;
            end
            bae_pkg::ST_CHECK: begin
                ow   = '{ch: bae_pkg::charset_char(acc_top), fin: (cidx_reg == 3'd5)};
                emit = 1'b1;
                if (cidx_reg == 3'd5) begin
                    ck       = '{op: bae_pkg::CK_INIT, sym: 5'd0};
                    buf_next = 12'd0;
                    cnt_next = 3'd0;
                    done     = 1'b1;
                end else begin
                    ck        = '{op: bae_pkg::CK_SHIFT, sym: 5'd0};
                    cidx_next = cidx_reg + 3'd1;
                end
            end
            default: begin
            end
        endcase

        if (done) begin
            in_message_next = !last_reg;
            state_next      = bae_pkg::ST_IDLE;
        end

        if (accept) begin
            start_inm = (state_reg == bae_pkg::ST_IDLE) ? in_message_reg : !last_reg;
            pidx_next = 3'd0;
            if (start_inm) begin
                state_next = bae_pkg::ST_DATA0;
            end else if (len == 4'd0) begin
                state_next = bae_pkg::ST_SEP;
            end else begin
                state_next = bae_pkg::ST_HIGH;
            end
        end else begin
            start_inm = in_message_reg;
        end
    end

    assign s_ready = (state_reg == bae_pkg::ST_IDLE) || (adv && done);
    assign accept  = s_valid && s_ready;
    assign ck_eff  = adv ? ck : '{op: bae_pkg::CK_HOLD, sym: 5'd0};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= bae_pkg::ST_IDLE;
            pidx_reg       <= 3'd0;
            cidx_reg       <= 3'd0;
            buf_reg        <= 12'd0;
            cnt_reg        <= 3'd0;
            in_message_reg <= 1'b0;
        end else if (adv) begin
            state_reg      <= state_next;
            pidx_reg       <= pidx_next;
            cidx_reg       <= cidx_next;
            buf_reg        <= buf_next;
            cnt_reg        <= cnt_next;
            in_message_reg <= in_message_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            byte_reg <= s_data_byte;
            last_reg <= s_last_byte;
        end
    end

    bae_checksum u_checksum (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ck_eff),
        .acc_top (acc_top)
    );

    bae_out_slot u_out_slot (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .load           (emit && adv),
        .word_in        (ow),
        .slot_free      (slot_free),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_address_char (m_address_char),
        .m_final_char   (m_final_char)
    );

    a_idle_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == bae_pkg::ST_IDLE && !in_message_reg) |-> (buf_reg == 12'd0 && cnt_reg == 3'd0))
        else $error("leftover bits while awaiting a first byte");

    a_data1_bits: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == bae_pkg::ST_DATA1) |-> (cnt_reg >= 3'd5))
        else $error("second symbol without five buffered bits");

    a_pad_only_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == bae_pkg::ST_PAD) |-> (last_reg && cnt_reg != 3'd0))
        else $error("pad symbol outside the last byte");

    a_final_ends_msg: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && adv && ow.fin) |=> !in_message_reg)
        else $error("message still open after final character");

endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Testbench for the bech32 address encoder: checks every character against a predictor.
module tb_top;

    localparam logic [3:0] ADDR_PREFIX_CHARS  = {bae_pkg::REG_PREFIX_CHARS, 3'b000};
    localparam logic [3:0] ADDR_PREFIX_LENGTH = {bae_pkg::REG_PREFIX_LENGTH, 3'b000};
    localparam int unsigned CYCLE_LIMIT  = 600000;
    localparam int unsigned RANDOM_BYTES = 500;

    class address_predictor;
        bit [63:0]   prefix_chars  = 64'h626b63;
        bit [3:0]    prefix_length = 4'd3;
        bit [29:0]   bch_acc       = bae_pkg::CKS_INIT;
        bit [11:0]   pending_bits;
        int unsigned pending_count;
        bit          open_msg;
        int unsigned errors;
        bae_pkg::out_word_t expected_chars[$];
        bit [29:0]   bch_gen[5] = '{30'h3b6a57b2, 30'h26508e6d, 30'h1ea119fa,
                                    30'h3d4233dd, 30'h2a1462b3};
        string       alphabet = "qpzry9x8gf2tvdw0s3jn54khce6mua7l";

        function void bch_step(bit [4:0] sym);
            bit [4:0] top;
            top = bch_acc[29:25];
            bch_acc = {bch_acc[24:0], sym};
            for (int j = 0; j < 5; j++) begin
                if (top[j]) begin
                    bch_acc ^= bch_gen[j];
                end
            end
        endfunction

        function void push_char(bit [6:0] ch, bit fin);
            bae_pkg::out_word_t w;
            w.ch = ch;
            w.fin = fin;
            expected_chars.push_back(w);
        endfunction

        function void push_symbol(bit [4:0] sym);
            byte c;
            c = alphabet[sym];
            bch_step(sym);
            push_char(c[6:0], 1'b0);
        endfunction

        function void take_byte(bit [7:0] data, bit last);
            int unsigned len;
            bit [6:0]    c;
            bit [11:0]   t;
            bit [4:0]    sym;
            byte         cc;
            if (!open_msg) begin
                len = (prefix_length > bae_pkg::MAX_PREFIX_LENGTH)
                      ? 32'(bae_pkg::MAX_PREFIX_LENGTH) : 32'(prefix_length);
                bch_acc = bae_pkg::CKS_INIT;
                pending_bits = '0;
                pending_count = 0;
                for (int i = 0; i < len; i++) begin
                    c = prefix_chars[8*i +: 7];
                    bch_step({3'd0, c[6:5]});
                end
                bch_step(5'd0);
                for (int i = 0; i < len; i++) begin
                    c = prefix_chars[8*i +: 7];
                    bch_step(c[4:0]);
                    push_char(c, 1'b0);
                end
                push_char(bae_pkg::SEP_CHAR, 1'b0);
                open_msg = 1'b1;
            end
            pending_bits = {pending_bits[3:0], data};
            pending_count += 8;
            while (pending_count >= 5) begin
                pending_count -= 5;
                t = pending_bits >> pending_count;
                push_symbol(t[4:0]);
            end
            if (last) begin
                if (pending_count != 0) begin
                    t = pending_bits << (5 - pending_count);
                    push_symbol(t[4:0]);
                end
                repeat (6) bch_step(5'd0);
                bch_acc ^= 30'd1;
                for (int i = 0; i < 6; i++) begin
                    sym = bch_acc[5*(5-i) +: 5];
                    cc = alphabet[sym];
                    push_char(cc[6:0], i == 5);
                end
                bch_acc = bae_pkg::CKS_INIT;
                pending_bits = '0;
                pending_count = 0;
                open_msg = 1'b0;
            end
        endfunction

        function void check_char(bit [6:0] ch, bit fin);
            bae_pkg::out_word_t w;
            if (expected_chars.size() == 0) begin
                $error("unexpected word: address_char %h final_char %b", ch, fin);
                errors++;
                return;
            end
            w = expected_chars.pop_front();
            if (w.ch != ch) begin
                $error("address_char: expected %h, actual %h", w.ch, ch);
                errors++;
            end
            if (w.fin != fin) begin
                $error("final_char: expected %b, actual %b", w.fin, fin);
                errors++;
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte = 8'd0;
    logic        s_last_byte = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [6:0]  m_address_char;
    logic        m_final_char;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = 4'd0;
    logic [63:0] pwdata = 64'd0;
    logic [63:0] prdata;
    logic        pready;

    bit               idling = 1'b1;
    int unsigned      cycle_count;
    address_predictor sb = new();

    bech32_address_encoder dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data_byte    (s_data_byte),
        .s_last_byte    (s_last_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_address_char (m_address_char),
        .m_final_char   (m_final_char),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                sb.take_byte(s_data_byte, s_last_byte);
            end
            if (m_valid && m_ready) begin
                sb.check_char(m_address_char, m_final_char);
            end
        end
    end

    always @(negedge aclk) begin
        m_ready = !(idling && $urandom_range(99) < 30);
    end

    // called and returns at a falling edge; valid stays up for a following word
    task automatic send_word(input logic [7:0] data, input logic last);
        while (idling && $urandom_range(99) < 30) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_data_byte = data;
        s_last_byte = last;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic send_message(input int unsigned n);
        for (int i = 0; i < n; i++) begin
            send_word(8'($urandom_range(0, 255)), i == n - 1);
        end
    endtask

    task automatic settle();
        s_valid = 1'b0;
        while (sb.expected_chars.size() != 0) @(posedge aclk);
        repeat (6) @(negedge aclk);
    endtask

    task automatic write_register(input logic [3:0] addr, input logic [63:0] value);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = addr;
        pwdata = value;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        if (addr == ADDR_PREFIX_LENGTH) begin
            sb.prefix_length = value[3:0];
        end else begin
            sb.prefix_chars = value;
        end
        @(negedge aclk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    initial begin
        int unsigned sent;
        int unsigned phase;
        int unsigned msgs;
        int unsigned len;
        int unsigned r;
        logic [63:0] plen_word;

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // reset prefix, extreme bytes
        send_word(8'h00, 1'b1);
        send_word(8'hff, 1'b1);
        settle();
        write_register(ADDR_PREFIX_CHARS, 64'hffff_ffff_ffff_ffff);
        write_register(ADDR_PREFIX_LENGTH, 64'd1);
        send_word(8'ha5, 1'b0);
        send_word(8'h5a, 1'b1);
        settle();
        write_register(ADDR_PREFIX_CHARS, 64'd0);
        write_register(ADDR_PREFIX_LENGTH, 64'd8);
        send_word(8'h3c, 1'b1);
        settle();
        // bit 7 set in every prefix char, length saturates
        write_register(ADDR_PREFIX_CHARS, 64'hf3e2_d1c0_b7a6_9584);
        write_register(ADDR_PREFIX_LENGTH, 64'd15);
        send_word(8'h01, 1'b0);
        send_word(8'h02, 1'b0);
        send_word(8'h04, 1'b0);
        send_word(8'h08, 1'b0);
        send_word(8'h10, 1'b1);
        settle();
        write_register(ADDR_PREFIX_LENGTH, 64'd0);
        send_word(8'h80, 1'b0);
        send_word(8'h7f, 1'b1);
        settle();
        // config change inside a message only affects the next one
        write_register(ADDR_PREFIX_LENGTH, 64'd4);
        send_word(8'hc3, 1'b0);
        settle();
        write_register(ADDR_PREFIX_CHARS, 64'h0000_0000_7863_6274);
        write_register(ADDR_PREFIX_LENGTH, 64'd2);
        send_word(8'h3c, 1'b1);
        send_word(8'h55, 1'b1);

        sent = 0;
        phase = 0;
        while (sent < RANDOM_BYTES) begin
            settle();
            r = $urandom_range(99);
            if (r < 10) begin
                plen_word = 64'($urandom_range(9, 15));
            end else if (r < 15) begin
                plen_word = 64'd0;
            end else begin
                plen_word = 64'($urandom_range(1, 8));
            end
            write_register(ADDR_PREFIX_CHARS, {$urandom, $urandom});
            write_register(ADDR_PREFIX_LENGTH, plen_word);
            idling = !(phase >= 3 && phase <= 6);
            msgs = $urandom_range(2, 6);
            repeat (msgs) begin
                len = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
                send_message(len);
                sent += len;
            end
            if ($urandom_range(4) == 0) begin
                len = $urandom_range(1, 3);
                repeat (len) send_word(8'($urandom_range(0, 255)), 1'b0);
                sent += len;
            end
            phase++;
        end
        send_word(8'h96, 1'b1);
        s_valid = 1'b0;

        while (sb.expected_chars.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (sb.errors == 0 && sb.expected_chars.size() == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
